### rtl/pla_pkg.sv
// pla_pkg: widths, register indexes and the sideband type of the point light attenuation block.
// Used by pla_sqrt, pla_div and point_light_attenuation_top; depends on nothing.
package pla_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int ATTEN_FRAC_BITS = 16;
   localparam int Q_FRAC          = 16;

   localparam int DIFF_W   = COORD_WIDTH + 1;
   localparam int COEF_W   = 32;
   localparam int RAD_W    = 31;
   localparam int SQ_W     = 2 * RAD_W;
   localparam int SUM_W    = SQ_W + 2;
   localparam int ROOT_W   = RAD_W;
   localparam int LIN_W    = COEF_W + ROOT_W;
   localparam int S16_W    = SQ_W - Q_FRAC;
   localparam int QSPLIT   = S16_W / 2;
   localparam int QPART_W  = COEF_W + S16_W - QSPLIT;
   localparam int QP_W     = COEF_W + S16_W;
   localparam int QCAP_BIT = 49;
   localparam int T1_W     = LIN_W - Q_FRAC;
   localparam int T2_W     = QCAP_BIT - Q_FRAC + 1;
   localparam int DEN_W    = 48;
   localparam int ATT_W    = ATTEN_FRAC_BITS + 1;
   localparam int FALL_W   = ATTEN_FRAC_BITS;
   localparam int R20_W    = RAD_W + 5;
   localparam int FNUM_W   = R20_W + ATTEN_FRAC_BITS;
   localparam int FDEN_W   = RAD_W + 4;
   localparam int BREM_W   = Q_FRAC + ATTEN_FRAC_BITS + 1;
   localparam int PROD_W   = ATT_W + FALL_W;

   localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(65536);
   localparam logic [ATT_W-1:0] ATT_ONE      = ATT_W'(1) << ATTEN_FRAC_BITS;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUADRATIC = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS    = 2'd2;

   typedef struct packed {
      logic outside;
      logic fall_en;
   } pla_tag_type;

endpackage

### rtl/point_light_attenuation_top.sv
// point_light_attenuation_top: point light distance attenuation with radius cut-off.
// Depends on pla_pkg, pla_sqrt and pla_div.
//
// Takes one light/surface point pair per cycle while not stalled and returns one
// attenuation word per pair, in order: three stages form the squared distance and
// the radius test, 31 stages take the square root one bit at a time, three stages
// build the denominator and the falloff operands, 17 stages run both divisions one
// quotient bit at a time, and two stages apply the falloff and drive the output
// register. The whole pipeline advances together; a stall on the result side freezes
// it, and req_stall rises only while the output word is waiting and stalled. The
// configuration registers are read live, so write them only while no word is in flight.
module point_light_attenuation_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [pla_pkg::COORD_WIDTH-1:0] req_light_x,
   input  logic signed [pla_pkg::COORD_WIDTH-1:0] req_light_y,
   input  logic signed [pla_pkg::COORD_WIDTH-1:0] req_light_z,
   input  logic signed [pla_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [pla_pkg::COORD_WIDTH-1:0] req_point_y,
   input  logic signed [pla_pkg::COORD_WIDTH-1:0] req_point_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [pla_pkg::ATT_W-1:0]             rsp_attenuation,
   output logic                                  rsp_outside_radius,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pla_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pla_pkg::COEF_W-1:0]            csr_data
);
   import pla_pkg::*;

   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_WIDTH-1:0] a,
                                                  input logic signed [COORD_WIDTH-1:0] b);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(a) - DIFF_W'(b);
      return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   // Global advance: every stage moves when the output word is free or taken.
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Configuration registers.
   logic [COEF_W-1:0] linear_ff, quad_ff;
   logic [RAD_W-1:0]  radius_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         linear_ff <= '0;
         quad_ff   <= '0;
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LINEAR:    linear_ff <= csr_data;
            CSR_QUADRATIC: quad_ff   <= csr_data;
            CSR_RADIUS:    radius_ff <= csr_data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage A: per-axis absolute differences.
   logic              a_valid_ff;
   logic [DIFF_W-1:0] a_dx_ff, a_dy_ff, a_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else if (advance) a_valid_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         a_dx_ff <= abs_diff(req_light_x, req_point_x);
         a_dy_ff <= abs_diff(req_light_y, req_point_y);
         a_dz_ff <= abs_diff(req_light_z, req_point_z);
      end
   end

   // Stage B: squares and squared radius; an axis beyond the radius already marks outside.
   logic            b_valid_ff, b_gt_ff;
   logic [SQ_W-1:0] b_sx_ff, b_sy_ff, b_sz_ff, b_rr_ff;
   logic [DIFF_W-1:0] r_wide;
   assign r_wide = DIFF_W'(radius_ff);

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else if (advance) b_valid_ff <= a_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         b_gt_ff <= (a_dx_ff > r_wide) || (a_dy_ff > r_wide) || (a_dz_ff > r_wide);
         b_sx_ff <= SQ_W'(a_dx_ff[RAD_W-1:0]) * SQ_W'(a_dx_ff[RAD_W-1:0]);
         b_sy_ff <= SQ_W'(a_dy_ff[RAD_W-1:0]) * SQ_W'(a_dy_ff[RAD_W-1:0]);
         b_sz_ff <= SQ_W'(a_dz_ff[RAD_W-1:0]) * SQ_W'(a_dz_ff[RAD_W-1:0]);
         b_rr_ff <= SQ_W'(radius_ff) * SQ_W'(radius_ff);
      end
   end

   // Stage C: squared distance and the radius test.
   logic             c_valid_ff;
   pla_tag_type      c_tag_ff;
   logic [SQ_W-1:0]  c_s_ff;
   logic [SUM_W-1:0] s_sum;
   assign s_sum = SUM_W'(b_sx_ff) + SUM_W'(b_sy_ff) + SUM_W'(b_sz_ff);

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else if (advance) c_valid_ff <= b_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         c_tag_ff.outside <= b_gt_ff || (s_sum > SUM_W'(b_rr_ff));
         c_tag_ff.fall_en <= 1'b0;
         c_s_ff           <= s_sum[SQ_W-1:0];
      end
   end

   // Square root of the squared distance.
   logic              q_valid;
   pla_tag_type       q_tag;
   logic [SQ_W-1:0]   q_s;
   logic [ROOT_W-1:0] q_d;

   pla_sqrt u_sqrt (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (c_valid_ff),
      .in_tag       (c_tag_ff),
      .in_radicand  (c_s_ff),
      .out_valid    (q_valid),
      .out_tag      (q_tag),
      .out_radicand (q_s),
      .out_root     (q_d)
   );

   // Stage M: coefficient products (quadratic split in two halves) and falloff operands.
   logic               m_valid_ff;
   pla_tag_type        m_tag_ff;
   logic [LIN_W-1:0]   m_p1_ff;
   logic [QPART_W-1:0] m_qlo_ff, m_qhi_ff;
   logic [FNUM_W-1:0]  m_fnum_ff;
   logic [FDEN_W-1:0]  m_fden_ff;
   logic [S16_W-1:0]   s16;
   logic [RAD_W-1:0]   rmd;
   logic [R20_W-1:0]   r20, d20, r11;

   always_comb begin
      s16 = q_s[SQ_W-1:Q_FRAC];
      rmd = radius_ff - q_d;
      r20 = R20_W'({rmd, 4'b0}) + R20_W'({rmd, 2'b0});
      d20 = R20_W'({q_d, 4'b0}) + R20_W'({q_d, 2'b0});
      r11 = R20_W'({radius_ff, 3'b0}) + R20_W'({radius_ff, 1'b0}) + R20_W'(radius_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) m_valid_ff <= 1'b0;
      else if (advance) m_valid_ff <= q_valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         m_tag_ff.outside <= q_tag.outside;
         m_tag_ff.fall_en <= d20 > r11;
         m_p1_ff   <= LIN_W'(linear_ff) * LIN_W'(q_d);
         m_qlo_ff  <= QPART_W'(quad_ff) * QPART_W'(s16[QSPLIT-1:0]);
         m_qhi_ff  <= QPART_W'(quad_ff) * QPART_W'(s16[S16_W-1:QSPLIT]);
         m_fnum_ff <= {r20, {ATTEN_FRAC_BITS{1'b0}}};
         m_fden_ff <= FDEN_W'({radius_ff, 3'b0}) + FDEN_W'(radius_ff);
      end
   end

   // Stage N: linear term, quadratic term saturated at 2^33.
   logic              n_valid_ff;
   pla_tag_type       n_tag_ff;
   logic [T1_W-1:0]   n_t1_ff;
   logic [T2_W-1:0]   n_t2_ff;
   logic [FNUM_W-1:0] n_fnum_ff;
   logic [FDEN_W-1:0] n_fden_ff;
   logic [QP_W-1:0]   qp;
   assign qp = QP_W'(m_qlo_ff) + (QP_W'(m_qhi_ff) << QSPLIT);

   always_ff @(posedge clock) begin
      if (reset) n_valid_ff <= 1'b0;
      else if (advance) n_valid_ff <= m_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         n_tag_ff  <= m_tag_ff;
         n_t1_ff   <= m_p1_ff[LIN_W-1:Q_FRAC];
         n_t2_ff   <= (|qp[QP_W-1:QCAP_BIT]) ? (T2_W'(1) << (QCAP_BIT - Q_FRAC))
                                             : T2_W'(qp[QCAP_BIT-1:Q_FRAC]);
         n_fnum_ff <= m_fnum_ff;
         n_fden_ff <= m_fden_ff;
      end
   end

   // Stage O: denominator in Q16.16.
   logic              o_valid_ff;
   pla_tag_type       o_tag_ff;
   logic [DEN_W-1:0]  o_den_ff;
   logic [FNUM_W-1:0] o_fnum_ff;
   logic [FDEN_W-1:0] o_fden_ff;

   always_ff @(posedge clock) begin
      if (reset) o_valid_ff <= 1'b0;
      else if (advance) o_valid_ff <= n_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         o_tag_ff  <= n_tag_ff;
         o_den_ff  <= (DEN_W'(1) << Q_FRAC) + DEN_W'(n_t1_ff) + DEN_W'(n_t2_ff);
         o_fnum_ff <= n_fnum_ff;
         o_fden_ff <= n_fden_ff;
      end
   end

   // Base attenuation and falloff quotients.
   logic              v_valid;
   pla_tag_type       v_tag;
   logic [ATT_W-1:0]  v_att;
   logic [FALL_W-1:0] v_fall;

   pla_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (o_valid_ff),
      .in_tag    (o_tag_ff),
      .in_denom  (o_den_ff),
      .in_fnum   (o_fnum_ff),
      .in_fden   (o_fden_ff),
      .out_valid (v_valid),
      .out_tag   (v_tag),
      .out_att   (v_att),
      .out_fall  (v_fall)
   );

   // Stage P: apply the falloff product.
   logic              p_valid_ff;
   pla_tag_type       p_tag_ff;
   logic [ATT_W-1:0]  p_att_ff;
   logic [PROD_W-1:0] p_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) p_valid_ff <= 1'b0;
      else if (advance) p_valid_ff <= v_valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         p_tag_ff  <= v_tag;
         p_att_ff  <= v_att;
         p_prod_ff <= PROD_W'(v_att) * PROD_W'(v_fall);
      end
   end

   // Output register: drop the value for points beyond the radius.
   logic [ATT_W-1:0] rsp_att_ff;
   logic             rsp_outside_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= p_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_outside_ff <= p_tag_ff.outside;
         if (p_tag_ff.outside) begin
            rsp_att_ff <= '0;
         end else if (p_tag_ff.fall_en) begin
            rsp_att_ff <= p_prod_ff[PROD_W-1:ATTEN_FRAC_BITS];
         end else begin
            rsp_att_ff <= p_att_ff;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_attenuation    = rsp_att_ff;
   assign rsp_outside_radius = rsp_outside_ff;

   a_outside_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_outside_ff |-> rsp_att_ff == '0)
      else $error("outside word carries nonzero attenuation");

   a_att_bound : assert property (@(posedge clock) disable iff (reset)
      v_valid |-> v_att <= ATT_ONE)
      else $error("base attenuation above one");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled without a stalled output word");

endmodule

### rtl/pla_sqrt.sv
// pla_sqrt: pipelined floor square root, one root bit per register stage.
// Depends on pla_pkg; carries the radicand and the sideband tag alongside.
module pla_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  pla_pkg::pla_tag_type      in_tag,
   input  logic [pla_pkg::SQ_W-1:0]  in_radicand,
   output logic                      out_valid,
   output pla_pkg::pla_tag_type      out_tag,
   output logic [pla_pkg::SQ_W-1:0]  out_radicand,
   output logic [pla_pkg::ROOT_W-1:0] out_root
);
   import pla_pkg::*;

   logic              valid_ff [ROOT_W];
   pla_tag_type       tag_ff   [ROOT_W];
   logic [SQ_W-1:0]   rad_ff   [ROOT_W];
   logic [SQ_W-1:0]   rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];

   logic              valid_at [ROOT_W+1];
   pla_tag_type       tag_at   [ROOT_W+1];
   logic [SQ_W-1:0]   rad_at   [ROOT_W+1];
   logic [SQ_W-1:0]   rem_at   [ROOT_W+1];
   logic [ROOT_W-1:0] root_at  [ROOT_W+1];

   assign valid_at[0] = in_valid;
   assign tag_at[0]   = in_tag;
   assign rad_at[0]   = in_radicand;
   assign rem_at[0]   = in_radicand;
   assign root_at[0]  = '0;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [SQ_W:0]     test;
      logic              take;
      logic [SQ_W-1:0]   rem_in;
      logic [ROOT_W-1:0] root_in;

      // Trial root adds 2^B: the square grows by root*2^(B+1) + 2^(2B).
      always_comb begin
         test    = ((SQ_W+1)'(root_at[k]) << (B + 1)) + ((SQ_W+1)'(1) << (2 * B));
         take    = {1'b0, rem_at[k]} >= test;
         rem_in  = take ? rem_at[k] - test[SQ_W-1:0] : rem_at[k];
         root_in = take ? (root_at[k] | (ROOT_W'(1) << B)) : root_at[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_at[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            tag_ff[k]  <= tag_at[k];
            rad_ff[k]  <= rad_at[k];
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end

      assign valid_at[k+1] = valid_ff[k];
      assign tag_at[k+1]   = tag_ff[k];
      assign rad_at[k+1]   = rad_ff[k];
      assign rem_at[k+1]   = rem_ff[k];
      assign root_at[k+1]  = root_ff[k];
   end

   assign out_valid    = valid_at[ROOT_W];
   assign out_tag      = tag_at[ROOT_W];
   assign out_radicand = rad_at[ROOT_W];
   assign out_root     = root_at[ROOT_W];

endmodule

### rtl/pla_div.sv
// pla_div: two restoring dividers in lockstep, one quotient bit per stage each.
// Depends on pla_pkg; forms 2^32/denominator and the radius falloff quotient.
module pla_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  pla_pkg::pla_tag_type        in_tag,
   input  logic [pla_pkg::DEN_W-1:0]   in_denom,
   input  logic [pla_pkg::FNUM_W-1:0]  in_fnum,
   input  logic [pla_pkg::FDEN_W-1:0]  in_fden,
   output logic                        out_valid,
   output pla_pkg::pla_tag_type        out_tag,
   output logic [pla_pkg::ATT_W-1:0]   out_att,
   output logic [pla_pkg::FALL_W-1:0]  out_fall
);
   import pla_pkg::*;

   localparam int BCMP_W = DEN_W + ATT_W;
   localparam int FCMP_W = FNUM_W + 1;

   logic              valid_ff [ATT_W];
   pla_tag_type       tag_ff   [ATT_W];
   logic [DEN_W-1:0]  den_ff   [ATT_W];
   logic [FDEN_W-1:0] fden_ff  [ATT_W];
   logic [BREM_W-1:0] brem_ff  [ATT_W];
   logic [FNUM_W-1:0] frem_ff  [ATT_W];
   logic [ATT_W-1:0]  att_ff   [ATT_W];
   logic [FALL_W-1:0] fall_ff  [ATT_W];

   logic              valid_at [ATT_W+1];
   pla_tag_type       tag_at   [ATT_W+1];
   logic [DEN_W-1:0]  den_at   [ATT_W+1];
   logic [FDEN_W-1:0] fden_at  [ATT_W+1];
   logic [BREM_W-1:0] brem_at  [ATT_W+1];
   logic [FNUM_W-1:0] frem_at  [ATT_W+1];
   logic [ATT_W-1:0]  att_at   [ATT_W+1];
   logic [FALL_W-1:0] fall_at  [ATT_W+1];

   assign valid_at[0] = in_valid;
   assign tag_at[0]   = in_tag;
   assign den_at[0]   = in_denom;
   assign fden_at[0]  = in_fden;
   assign brem_at[0]  = BREM_W'(1) << (Q_FRAC + ATTEN_FRAC_BITS);
   assign frem_at[0]  = in_fnum;
   assign att_at[0]   = '0;
   assign fall_at[0]  = '0;

   for (genvar k = 0; k < ATT_W; k++) begin : g_stage
      localparam int J = ATT_W - 1 - k;
      logic [BCMP_W-1:0] bcmp;
      logic              btake;
      logic [BREM_W-1:0] brem_in;
      logic [ATT_W-1:0]  att_in;
      logic [FNUM_W-1:0] frem_in;
      logic [FALL_W-1:0] fall_in;

      always_comb begin
         bcmp    = BCMP_W'(den_at[k]) << J;
         btake   = BCMP_W'(brem_at[k]) >= bcmp;
         brem_in = btake ? brem_at[k] - bcmp[BREM_W-1:0] : brem_at[k];
         att_in  = att_at[k] | (ATT_W'(btake) << J);
      end

      if (k == 0) begin : g_fidle
         assign frem_in = frem_at[k];
         assign fall_in = fall_at[k];
      end else begin : g_fstep
         logic [FCMP_W-1:0] fcmp;
         logic              ftake;
         always_comb begin
            fcmp    = FCMP_W'(fden_at[k]) << J;
            ftake   = FCMP_W'(frem_at[k]) >= fcmp;
            frem_in = ftake ? frem_at[k] - fcmp[FNUM_W-1:0] : frem_at[k];
            fall_in = fall_at[k] | (FALL_W'(ftake) << J);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_at[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            tag_ff[k]  <= tag_at[k];
            den_ff[k]  <= den_at[k];
            fden_ff[k] <= fden_at[k];
            brem_ff[k] <= brem_in;
            frem_ff[k] <= frem_in;
            att_ff[k]  <= att_in;
            fall_ff[k] <= fall_in;
         end
      end

      assign valid_at[k+1] = valid_ff[k];
      assign tag_at[k+1]   = tag_ff[k];
      assign den_at[k+1]   = den_ff[k];
      assign fden_at[k+1]  = fden_ff[k];
      assign brem_at[k+1]  = brem_ff[k];
      assign frem_at[k+1]  = frem_ff[k];
      assign att_at[k+1]   = att_ff[k];
      assign fall_at[k+1]  = fall_ff[k];
   end

   assign out_valid = valid_at[ATT_W];
   assign out_tag   = tag_at[ATT_W];
   assign out_att   = att_at[ATT_W];
   assign out_fall  = fall_at[ATT_W];

endmodule
